[hdl/ftc_pkg.sv]
// Shared widths, latencies and the arctangent step table for the frustum coverage core.
// No dependencies.
`default_nettype none
package ftc_pkg;
    localparam int IN_W = 15;
    localparam int OUT_W = 17;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int RATIO_FRAC_BITS_DEF = 16;
    localparam int TAN_FRAC = 30;
    localparam int STEPS = 30;
    localparam int CW = 34;
    localparam int QB = 38;
    localparam int TW = QB + 1;
    localparam int LANE_LAT = STEPS + QB + 3;
    localparam int NUM_ANG = 8;

    typedef struct packed {
        logic vld;
        logic ok;
    } t_side;

    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] v;
        begin
            unique case (i)
                0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
                3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
                6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
                9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
                18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
                21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
                24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
                27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

[hdl/ftc_tan.sv]
// One tangent lane: pipelined rotation stages followed by a pipelined restoring divider.
// Depends on ftc_pkg.
`default_nettype none
module ftc_tan #(
    parameter int ANGLE_FRAC_BITS = ftc_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [ftc_pkg::IN_W-1:0]   i_angle,
    output logic signed [ftc_pkg::TW-1:0]          o_tan
);
    import ftc_pkg::*;

    localparam int NW = CW - 1 + TAN_FRAC;

    logic signed [CW-1:0] r_x [0:STEPS];
    logic signed [CW-1:0] r_y [0:STEPS];
    logic signed [CW-1:0] r_z [0:STEPS];
    logic [CW-1:0]        r_rem [0:QB];
    logic [QB-1:0]        r_dvd [0:QB];
    logic [QB-1:0]        r_q   [0:QB];
    logic [CW-2:0]        r_den [0:QB];
    logic                 r_neg [0:QB];
    logic signed [TW-1:0] r_tan;

    logic [CW-2:0]  ymag;
    logic [NW-1:0]  num;
    logic [CW-2:0]  den0;

    always_comb begin
        ymag = r_y[STEPS][CW-1] ? (CW-1)'(-r_y[STEPS]) : r_y[STEPS][CW-2:0];
        num  = {ymag, {TAN_FRAC{1'b0}}};
        den0 = (r_x[STEPS] < 1) ? (CW-1)'(1) : r_x[STEPS][CW-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CW'(1) <<< TAN_FRAC;
            r_y[0] <= '0;
            r_z[0] <= CW'(i_angle) <<< (TAN_FRAC - ANGLE_FRAC_BITS);
            for (int i = 0; i < STEPS; i++) begin
                if (!r_z[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed(CW'(atan_step(i)));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed(CW'(atan_step(i)));
                end
            end
            r_rem[0] <= CW'(num[NW-1:QB]);
            r_dvd[0] <= num[QB-1:0];
            r_q[0]   <= '0;
            r_den[0] <= den0;
            r_neg[0] <= r_y[STEPS][CW-1];
            for (int k = 0; k < QB; k++) begin
                if ({r_rem[k][CW-2:0], r_dvd[k][QB-1]} >= {1'b0, r_den[k]}) begin
                    r_rem[k+1] <= {r_rem[k][CW-2:0], r_dvd[k][QB-1]} - {1'b0, r_den[k]};
                    r_q[k+1]   <= {r_q[k][QB-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= {r_rem[k][CW-2:0], r_dvd[k][QB-1]};
                    r_q[k+1]   <= {r_q[k][QB-2:0], 1'b0};
                end
                r_dvd[k+1] <= {r_dvd[k][QB-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
            r_tan <= r_neg[QB] ? -$signed({1'b0, r_q[QB]}) : $signed({1'b0, r_q[QB]});
        end
    end

    assign o_tan = r_tan;
endmodule
`default_nettype wire

[hdl/frustum_tangent_coverage_core.sv]
// Throughput: one request per cycle while the output is not stalled; a stalled output
// freezes the whole pipeline in place.
// The depth is set by 30 rotation stages, 38 tangent divider stages and the ratio dividers.
// Reset clears only the valid bits; the data registers are not reset.
// Top level of the frustum coverage core; instantiates eight ftc_tan lanes.
// Depends on ftc_pkg and ftc_tan.
`default_nettype none
module frustum_tangent_coverage_core #(
    parameter int ANGLE_FRAC_BITS = ftc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RATIO_FRAC_BITS = ftc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic signed [ftc_pkg::IN_W-1:0]  i_rendered_left,
    input  wire logic signed [ftc_pkg::IN_W-1:0]  i_rendered_right,
    input  wire logic signed [ftc_pkg::IN_W-1:0]  i_rendered_up,
    input  wire logic signed [ftc_pkg::IN_W-1:0]  i_rendered_down,
    input  wire logic signed [ftc_pkg::IN_W-1:0]  i_requested_left,
    input  wire logic signed [ftc_pkg::IN_W-1:0]  i_requested_right,
    input  wire logic signed [ftc_pkg::IN_W-1:0]  i_requested_up,
    input  wire logic signed [ftc_pkg::IN_W-1:0]  i_requested_down,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_result_valid,
    output logic [ftc_pkg::OUT_W-1:0]             o_use_width,
    output logic [ftc_pkg::OUT_W-1:0]             o_use_height,
    output logic [ftc_pkg::OUT_W-1:0]             o_use_area,
    output logic [ftc_pkg::OUT_W-1:0]             o_served_width,
    output logic [ftc_pkg::OUT_W-1:0]             o_served_height,
    output logic [ftc_pkg::OUT_W-1:0]             o_served_area,
    output logic                                  o_request_outside
);
    import ftc_pkg::*;

    localparam longint ANGLE_LIMIT = (longint'(15533431) <<< ANGLE_FRAC_BITS) / 10000000;
    localparam int QR = RATIO_FRAC_BITS + 1;

    logic en;
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    logic signed [IN_W-1:0] in_ang [0:NUM_ANG-1];
    logic signed [IN_W-1:0] r_ang  [0:NUM_ANG-1];
    logic signed [TW-1:0]   tan_q  [0:NUM_ANG-1];
    logic                   ok_in;
    logic                   r_v0, r_ok0;
    t_side                  r_sb [1:LANE_LAT];

    always_comb begin
        in_ang[0] = i_rendered_left;
        in_ang[1] = i_rendered_right;
        in_ang[2] = i_rendered_up;
        in_ang[3] = i_rendered_down;
        in_ang[4] = i_requested_left;
        in_ang[5] = i_requested_right;
        in_ang[6] = i_requested_up;
        in_ang[7] = i_requested_down;
        ok_in = (in_ang[1] > in_ang[0]) && (in_ang[2] > in_ang[3])
             && (in_ang[5] > in_ang[4]) && (in_ang[6] > in_ang[7]);
        for (int k = 0; k < NUM_ANG; k++) begin
            if (longint'(in_ang[k]) > ANGLE_LIMIT || longint'(in_ang[k]) < -ANGLE_LIMIT) begin
                ok_in = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int j = 1; j <= LANE_LAT; j++) begin
                r_sb[j].vld <= 1'b0;
            end
        end else if (en) begin
            r_v0 <= i_valid;
            r_sb[1].vld <= r_v0;
            r_sb[1].ok <= r_ok0;
            for (int j = 1; j < LANE_LAT; j++) begin
                r_sb[j+1].vld <= r_sb[j].vld;
                r_sb[j+1].ok <= r_sb[j].ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok0 <= ok_in;
            for (int k = 0; k < NUM_ANG; k++) begin
                r_ang[k] <= in_ang[k];
            end
        end
    end

    for (genvar g = 0; g < NUM_ANG; g++) begin : g_lane
        ftc_tan #(
            .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
        ) u_tan (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_angle (r_ang[g]),
            .o_tan   (tan_q[g])
        );
    end

    logic signed [TW:0]   rsh, rsv, qsh, qsv, oh, ov;
    logic signed [TW-1:0] hi_h, lo_h, hi_v, lo_v;
    logic                 span_ok, outside;
    logic [TW-1:0]        num_c [0:3];
    logic [TW-1:0]        den_c [0:3];

    always_comb begin
        rsh = (TW+1)'(tan_q[1]) - (TW+1)'(tan_q[0]);
        rsv = (TW+1)'(tan_q[2]) - (TW+1)'(tan_q[3]);
        qsh = (TW+1)'(tan_q[5]) - (TW+1)'(tan_q[4]);
        qsv = (TW+1)'(tan_q[6]) - (TW+1)'(tan_q[7]);
        span_ok = (rsh > 0) && (rsv > 0) && (qsh > 0) && (qsv > 0);
        hi_h = (tan_q[1] < tan_q[5]) ? tan_q[1] : tan_q[5];
        lo_h = (tan_q[0] > tan_q[4]) ? tan_q[0] : tan_q[4];
        hi_v = (tan_q[2] < tan_q[6]) ? tan_q[2] : tan_q[6];
        lo_v = (tan_q[3] > tan_q[7]) ? tan_q[3] : tan_q[7];
        oh = (hi_h > lo_h) ? (TW+1)'(hi_h) - (TW+1)'(lo_h) : '0;
        ov = (hi_v > lo_v) ? (TW+1)'(hi_v) - (TW+1)'(lo_v) : '0;
        outside = (tan_q[4] < tan_q[0]) || (tan_q[5] > tan_q[1])
               || (tan_q[7] < tan_q[3]) || (tan_q[6] > tan_q[2]);
        num_c[0] = oh[TW-1:0];
        den_c[0] = rsh[TW-1:0];
        num_c[1] = ov[TW-1:0];
        den_c[1] = rsv[TW-1:0];
        num_c[2] = oh[TW-1:0];
        den_c[2] = qsh[TW-1:0];
        num_c[3] = ov[TW-1:0];
        den_c[3] = qsv[TW-1:0];
    end

    logic [TW:0]   r_rem [0:QR][0:3];
    logic [QR-1:0] r_bit [0:QR][0:3];
    logic [QR-1:0] r_q   [0:QR][0:3];
    logic [TW-1:0] r_den [0:QR][0:3];
    logic          r_rv  [0:QR];
    logic          r_rok [0:QR];
    logic          r_rout[0:QR];
    logic [2*QR-1:0] r_pu, r_ps;
    logic [QR-1:0]   r_mq [0:3];
    logic            r_mv, r_mok, r_mout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QR; j++) begin
                r_rv[j] <= 1'b0;
            end
            r_mv    <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_rv[0] <= r_sb[LANE_LAT].vld;
            for (int j = 0; j < QR; j++) begin
                r_rv[j+1] <= r_rv[j];
            end
            r_mv    <= r_rv[QR];
            o_valid <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rok[0]  <= r_sb[LANE_LAT].ok && span_ok;
            r_rout[0] <= outside;
            for (int c = 0; c < 4; c++) begin
                r_rem[0][c] <= (TW+1)'(num_c[c] >> 1);
                r_bit[0][c] <= {num_c[c][0], {RATIO_FRAC_BITS{1'b0}}};
                r_q[0][c]   <= '0;
                r_den[0][c] <= den_c[c];
            end
            for (int j = 0; j < QR; j++) begin
                r_rok[j+1]  <= r_rok[j];
                r_rout[j+1] <= r_rout[j];
                for (int c = 0; c < 4; c++) begin
                    if ({r_rem[j][c][TW-1:0], r_bit[j][c][QR-1]} >= {1'b0, r_den[j][c]}) begin
                        r_rem[j+1][c] <= {r_rem[j][c][TW-1:0], r_bit[j][c][QR-1]}
                                       - {1'b0, r_den[j][c]};
                        r_q[j+1][c]   <= {r_q[j][c][QR-2:0], 1'b1};
                    end else begin
                        r_rem[j+1][c] <= {r_rem[j][c][TW-1:0], r_bit[j][c][QR-1]};
                        r_q[j+1][c]   <= {r_q[j][c][QR-2:0], 1'b0};
                    end
                    r_bit[j+1][c] <= {r_bit[j][c][QR-2:0], 1'b0};
                    r_den[j+1][c] <= r_den[j][c];
                end
            end
            r_pu   <= (2*QR)'(r_q[QR][0]) * (2*QR)'(r_q[QR][1]);
            r_ps   <= (2*QR)'(r_q[QR][2]) * (2*QR)'(r_q[QR][3]);
            r_mok  <= r_rok[QR];
            r_mout <= r_rout[QR];
            for (int c = 0; c < 4; c++) begin
                r_mq[c] <= r_q[QR][c];
            end
            o_result_valid    <= r_mok;
            o_use_width       <= r_mok ? OUT_W'(r_mq[0]) : '0;
            o_use_height      <= r_mok ? OUT_W'(r_mq[1]) : '0;
            o_use_area        <= r_mok ? OUT_W'(r_pu >> RATIO_FRAC_BITS) : '0;
            o_served_width    <= r_mok ? OUT_W'(r_mq[2]) : '0;
            o_served_height   <= r_mok ? OUT_W'(r_mq[3]) : '0;
            o_served_area     <= r_mok ? OUT_W'(r_ps >> RATIO_FRAC_BITS) : '0;
            o_request_outside <= r_mok && r_mout;
        end
    end
endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for frustum_tangent_coverage_core: directed and random frustum pairs
// are checked against a built-in tangent and overlap predictor. Depends on ftc_pkg and the core.
`default_nettype none
module tb;
    import ftc_pkg::*;

    localparam int AFB = ANGLE_FRAC_BITS_DEF;
    localparam int RFB = RATIO_FRAC_BITS_DEF;
    localparam int LATENCY = 75 + RFB;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint ANG_LIM = (64'd15533431 << AFB) / 64'd10000000;

    typedef logic signed [IN_W-1:0] t_ang;

    typedef struct packed {
        logic             vld;
        logic [OUT_W-1:0] uw, uh, ua, sw, sh, sa;
        logic             outside;
    } t_cov;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid;
    t_ang ang [NUM_ANG];
    logic o_result_valid, o_request_outside;
    logic [OUT_W-1:0] o_use_width, o_use_height, o_use_area;
    logic [OUT_W-1:0] o_served_width, o_served_height, o_served_area;

    t_cov coverage_q[$];
    int   errors = 0;
    int   sent = 0;
    int   checked = 0;
    int   valid_seen = 0;
    int   idle_cycles = 0;
    bit   sender_idles = 1'b1;
    bit   receiver_idles = 1'b1;
    int   hold_off = 0;
    int   long_stall = 0;

    initial begin
        for (int k = 0; k < NUM_ANG; k++) ang[k] = '0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    frustum_tangent_coverage_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_rendered_left(ang[0]), .i_rendered_right(ang[1]),
        .i_rendered_up(ang[2]), .i_rendered_down(ang[3]),
        .i_requested_left(ang[4]), .i_requested_right(ang[5]),
        .i_requested_up(ang[6]), .i_requested_down(ang[7]),
        .o_valid(o_valid), .i_ready(i_ready), .o_result_valid(o_result_valid),
        .o_use_width(o_use_width), .o_use_height(o_use_height), .o_use_area(o_use_area),
        .o_served_width(o_served_width), .o_served_height(o_served_height),
        .o_served_area(o_served_area), .o_request_outside(o_request_outside)
    );

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint tan_of(longint a);
        longint z, x, y, dx, dy;
        z = a * (longint'(1) << (TAN_FRAC - AFB));
        x = longint'(1) << TAN_FRAC;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_step(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_step(i));
            end
        end
        if (x < 1) x = 1;
        return (y * (longint'(1) << TAN_FRAC)) / x;
    endfunction

    function automatic longint span_overlap(longint alo, longint ahi, longint blo, longint bhi);
        longint hi, lo;
        hi = (ahi < bhi) ? ahi : bhi;
        lo = (alo > blo) ? alo : blo;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic longint fraction_of(longint num, longint den);
        if (den <= 0 || num <= 0) return 0;
        return (num << RFB) / den;
    endfunction

    function automatic t_cov predict_coverage(t_ang a [NUM_ANG]);
        t_cov c;
        longint v [NUM_ANG];
        longint t [NUM_ANG];
        longint rsh, rsv, qsh, qsv, oh, ov, uw, uh, sw, sh;
        bit ok;
        c = '0;
        ok = 1'b1;
        for (int k = 0; k < NUM_ANG; k++) begin
            v[k] = longint'(a[k]);
            if (v[k] > ANG_LIM || v[k] < -ANG_LIM) ok = 1'b0;
        end
        if (!(v[1] > v[0]) || !(v[2] > v[3]) || !(v[5] > v[4]) || !(v[6] > v[7])) ok = 1'b0;
        if (!ok) return c;
        for (int k = 0; k < NUM_ANG; k++) t[k] = tan_of(v[k]);
        rsh = t[1] - t[0]; rsv = t[2] - t[3];
        qsh = t[5] - t[4]; qsv = t[6] - t[7];
        if (rsh <= 0 || rsv <= 0 || qsh <= 0 || qsv <= 0) return c;
        oh = span_overlap(t[0], t[1], t[4], t[5]);
        ov = span_overlap(t[3], t[2], t[7], t[6]);
        uw = fraction_of(oh, rsh); uh = fraction_of(ov, rsv);
        sw = fraction_of(oh, qsh); sh = fraction_of(ov, qsv);
        c.vld = 1'b1;
        c.uw = uw[OUT_W-1:0];
        c.uh = uh[OUT_W-1:0];
        c.ua = OUT_W'((uw * uh) >> RFB);
        c.sw = sw[OUT_W-1:0];
        c.sh = sh[OUT_W-1:0];
        c.sa = OUT_W'((sw * sh) >> RFB);
        c.outside = (t[4] < t[0]) || (t[5] > t[1]) || (t[7] < t[3]) || (t[6] > t[2]);
        return c;
    endfunction

    task automatic send_request(t_ang a [NUM_ANG]);
        if (sender_idles && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        ang = a;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        coverage_q.push_back(predict_coverage(a));
        sent++;
        @(negedge i_clk);
    endtask

    // The receiver stalls in random bursts, or for a long fixed stretch when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (long_stall > 0) begin
            i_ready <= 1'b0;
            hold_off <= long_stall;
            long_stall = 0;
        end else if (hold_off > 0) begin
            i_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (receiver_idles && i_ready && $urandom_range(0, 7) == 0) begin
            i_ready <= 1'b0;
            hold_off <= $urandom_range(0, 12);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cov e;
        if (i_rst_n && o_valid && i_ready) begin
            if (coverage_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual valid=%0b",
                         $time, o_result_valid);
                errors++;
            end else begin
                e = coverage_q.pop_front();
                check_field("result_valid", OUT_W'(e.vld), OUT_W'(o_result_valid));
                check_field("use_width", e.uw, o_use_width);
                check_field("use_height", e.uh, o_use_height);
                check_field("use_area", e.ua, o_use_area);
                check_field("served_width", e.sw, o_served_width);
                check_field("served_height", e.sh, o_served_height);
                check_field("served_area", e.sa, o_served_area);
                check_field("request_outside", OUT_W'(e.outside), OUT_W'(o_request_outside));
                checked++;
                if (e.vld) valid_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic t_ang rand_in_limit();
        return t_ang'($signed($urandom_range(0, 2 * ANG_LIM)) - ANG_LIM);
    endfunction

    // Builds a well-formed pair: sane angles with ordered bounds.
    function automatic void make_frustum(ref t_ang a [NUM_ANG]);
        t_ang p, q;
        for (int k = 0; k < NUM_ANG; k += 2) begin
            do begin
                p = rand_in_limit();
                q = rand_in_limit();
            end while (p == q);
            if (k == 0 || k == 4) begin
                a[k] = (p < q) ? p : q; a[k+1] = (p < q) ? q : p;
            end else begin
                a[k] = (p > q) ? p : q; a[k+1] = (p > q) ? q : p;
            end
        end
    endfunction

    task automatic test_directed();
        t_ang a [NUM_ANG];
        t_ang lim;
        lim = t_ang'(ANG_LIM);
        a = '{-lim, lim, lim, -lim, -lim, lim, lim, -lim};
        send_request(a);
        a = '{-lim - 1, lim, lim, -lim, -lim, lim, lim, -lim};
        send_request(a);
        a = '{-lim, lim, lim, -lim, -lim, lim + 1, lim, -lim};
        send_request(a);
        a = '{t_ang'(-16384), 16383, 16383, -16384, -16384, 16383, 16383, -16384};
        send_request(a);
        a = '{100, 100, 200, 0, 0, 200, 200, 0};
        send_request(a);
        a = '{0, 200, 0, 100, 0, 200, 200, 0};
        send_request(a);
        a = '{0, 200, 200, 0, 300, 200, 200, 0};
        send_request(a);
        a = '{0, 1, 1, 0, 0, 1, 1, 0};
        send_request(a);
        a = '{-4000, -1000, 3000, 1000, 1000, 4000, -1000, -3000};
        send_request(a);
        a = '{-1000, 1000, 1000, -1000, -500, 500, 500, -500};
        send_request(a);
        a = '{-500, 500, 500, -500, -1000, 1000, 1000, -1000};
        send_request(a);
        a = '{-1000, 1000, 1000, -1000, -1000, 1000, 1000, -1000};
        send_request(a);
        a = '{-lim, -lim + 1, lim, lim - 1, lim - 1, lim, -lim + 1, -lim};
        send_request(a);
        a = '{0, 0, 0, 0, 0, 0, 0, 0};
        send_request(a);
    endtask

    task automatic test_random(int count);
        t_ang a [NUM_ANG];
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8) begin
                make_frustum(a);
            end else begin
                for (int k = 0; k < NUM_ANG; k++) a[k] = t_ang'($urandom());
            end
            send_request(a);
        end
    endtask

    task automatic test_backpressure();
        t_ang a [NUM_ANG];
        long_stall = 300;
        for (int n = 0; n < 150; n++) begin
            make_frustum(a);
            send_request(a);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (coverage_q.size() != 0 && guard < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(800);
        test_backpressure();
        test_random(700);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        test_random(200);
        drain();
        $display("Sent %0d requests, checked %0d results, %0d of them valid pairs.",
                 sent, checked, valid_seen);
        if (errors == 0 && coverage_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
